// ----- rtl/core/bcr_pkg.sv -----
// shared types and constants of the band column reducer
package bcr_pkg;

  localparam int MAX_COLUMN_ENTRIES_DEF = 4096;
  localparam int N_BANDS = 3;
  localparam int BAND_W = 8;
  localparam int COUNT_W = 13;
  localparam int RULE_W = 2;

  localparam logic [RULE_W-1:0] RULE_NEAREST = 2'd0;
  localparam logic [RULE_W-1:0] RULE_MEAN = 2'd1;
  localparam logic [RULE_W-1:0] RULE_MAX = 2'd2;
  localparam logic [RULE_W-1:0] RULE_RESET = RULE_MAX;

  typedef logic [N_BANDS-1:0][BAND_W-1:0] band_vec_t;

  // control from the sequencer to the column accumulator
  typedef struct packed {
    logic update;
    logic last;
    logic clear;
  } acc_ctrl_t;

endpackage

// ----- rtl/core/band_column_reducer_top.sv -----
// Band column reducer: reduces the three-band samples of one display column to one sample.
// A sample that does not close its column goes through accept and state update. A closing
// sample adds a final output step under the nearest and max rules; under the mean rule the one
// shared restoring divider first runs once per band (start, 9 compare-subtract steps, capture,
// ending early when the quotient saturates). The input is not ready while an item is at work;
// a finished result waits in the output register and the next sample is taken meanwhile.
// The rule register is written at configuration addresses 0 to 3 and read at every address.
module band_column_reducer_top import bcr_pkg::*; #(
  parameter int MAX_COLUMN_ENTRIES = MAX_COLUMN_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: sample_low, sample_mid, sample_high, column_count, zero pad
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        s_tlast,
  // m_tdata: out_low, out_mid, out_high
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CntW = $clog2(MAX_COLUMN_ENTRIES + 1);
  localparam int SumW = $clog2(255 * MAX_COLUMN_ENTRIES + 1);
  localparam int DivW = CntW + BAND_W + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACC = 3'd1;
  localparam logic [2:0] ST_DSTART = 3'd2;
  localparam logic [2:0] ST_DWAIT = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;

  logic [2:0]            state;
  logic [RULE_W-1:0]     column_rule;
  band_vec_t             item_smp;
  logic [COUNT_W-1:0]    item_cnt;
  logic                  item_last;
  logic [CntW-1:0]       count_c;
  logic [CntW-1:0]       middle;
  logic [1:0]            band;
  band_vec_t             mean_q;
  acc_ctrl_t             acc_ctrl;
  logic [N_BANDS-1:0][SumW-1:0] sums;
  band_vec_t             maxima;
  band_vec_t             picked;
  band_vec_t             result;
  logic                  div_start;
  logic                  div_done;
  logic [BAND_W-1:0]     div_q;
  logic [SumW-1:0]       div_sum;
  logic                  out_load;
  logic                  s_xact;

  // configuration port
  assign pready = 1'b1;
  assign prdata = 32'(column_rule);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_rule <= RULE_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      column_rule <= pwdata[RULE_W-1:0];
    end
  end

  // clamp the count to 1..MAX_COLUMN_ENTRIES
  always_comb begin
    if (item_cnt == '0) begin
      count_c = CntW'(1);
    end else if (32'(item_cnt) > 32'(MAX_COLUMN_ENTRIES)) begin
      count_c = CntW'(MAX_COLUMN_ENTRIES);
    end else begin
      count_c = CntW'(item_cnt);
    end
  end
  assign middle = (count_c - 1'b1) >> 1;

  assign s_tready = (state == ST_IDLE);
  assign s_xact = s_tvalid && s_tready;
  assign out_load = (state == ST_FIN) && (!m_tvalid || m_tready);

  assign acc_ctrl.update = (state == ST_ACC);
  assign acc_ctrl.last = item_last;
  assign acc_ctrl.clear = out_load;

  assign div_start = (state == ST_DSTART);

  always_comb begin
    case (band)
      2'd0: div_sum = sums[0];
      2'd1: div_sum = sums[1];
      default: div_sum = sums[2];
    endcase
  end

  always_comb begin
    case (column_rule)
      RULE_NEAREST: result = picked;
      RULE_MEAN: result = mean_q;
      default: result = maxima;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_xact) begin
      item_smp <= s_tdata[23:0];
      item_cnt <= s_tdata[36:24];
      item_last <= s_tlast;
    end
    if (state == ST_DWAIT && div_done) begin
      mean_q[band] <= div_q;
    end
    if (out_load) begin
      m_tdata <= result;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      band <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_xact) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          band <= '0;
          if (!item_last) begin
            state <= ST_IDLE;
          end else if (column_rule == RULE_MEAN) begin
            state <= ST_DSTART;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_DSTART: begin
          state <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (div_done) begin
            if (band == 2'(N_BANDS - 1)) begin
              state <= ST_FIN;
            end else begin
              band <= band + 1'b1;
              state <= ST_DSTART;
            end
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  bcr_accum #(
    .MaxEntries(MAX_COLUMN_ENTRIES),
    .CntW(CntW),
    .SumW(SumW)
  ) u_accum (
    .clk(clk),
    .rst(rst),
    .ctrl(acc_ctrl),
    .sample(item_smp),
    .middle(middle),
    .sums(sums),
    .maxima(maxima),
    .picked(picked)
  );

  bcr_div #(
    .CntW(CntW),
    .DivW(DivW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(DivW'(div_sum)),
    .divisor(count_c),
    .done(div_done),
    .quotient(div_q)
  );

  a_accept_to_acc: assert property (@(posedge clk) disable iff (rst)
    s_xact |=> state == ST_ACC)
    else $error("accepted transaction did not move to the update step");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DWAIT)
    else $error("divider finished while the sequencer was not waiting for it");

  a_fin_loads_output: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && state == ST_IDLE)
    else $error("closing result was not presented on the output");

endmodule

// ----- rtl/core/bcr_accum.sv -----
// per-column running sums, maxima, nearest pick and position
module bcr_accum import bcr_pkg::*; #(
  parameter int MaxEntries = MAX_COLUMN_ENTRIES_DEF,
  parameter int CntW = $clog2(MaxEntries + 1),
  parameter int SumW = $clog2(255 * MaxEntries + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  acc_ctrl_t                      ctrl,
  input  band_vec_t                      sample,
  input  logic [CntW-1:0]                middle,
  output logic [N_BANDS-1:0][SumW-1:0]   sums,
  output band_vec_t                      maxima,
  output band_vec_t                      picked
);

  localparam int PosW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam logic [SumW:0] SumCap = (SumW + 1)'(255 * MaxEntries);
  localparam logic [PosW-1:0] PosTop = PosW'(MaxEntries - 1);

  logic [PosW-1:0] position;
  logic            pick_en;

  assign pick_en = 32'(position) <= 32'(middle);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sums <= '0;
      maxima <= '0;
      picked <= '0;
      position <= '0;
    end else if (ctrl.update) begin
      for (int b = 0; b < N_BANDS; b++) begin
        logic [SumW:0] acc;
        acc = {1'b0, sums[b]} + (SumW + 1)'(sample[b]);
        sums[b] <= (acc > SumCap) ? SumCap[SumW-1:0] : acc[SumW-1:0];
        if (sample[b] > maxima[b]) begin
          maxima[b] <= sample[b];
        end
        if (pick_en) begin
          picked[b] <= sample[b];
        end
      end
      if (!ctrl.last && position < PosTop) begin
        position <= position + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/bcr_div.sv -----
// shared restoring divider, one quotient bit a cycle, quotient saturates at 255
module bcr_div import bcr_pkg::*; #(
  parameter int CntW = 13,
  parameter int DivW = CntW + BAND_W + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DivW-1:0]      dividend,
  input  logic [CntW-1:0]      divisor,
  output logic                 done,
  output logic [BAND_W-1:0]    quotient
);

  localparam int StepW = $clog2(BAND_W + 1);
  localparam logic [StepW-1:0] FirstStep = StepW'(BAND_W);

  logic             busy;
  logic [StepW-1:0] step;
  logic [DivW-1:0]  rem;
  logic [DivW-1:0]  dsh;
  logic             ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && ((step == FirstStep && ge) || step == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= DivW'(divisor) << BAND_W;
      step <= FirstStep;
      quotient <= '0;
    end else if (busy) begin
      // a hit on the first compare means the quotient does not fit in a band
      if (step == FirstStep && ge) begin
        quotient <= '1;
      end else begin
        quotient <= {quotient[BAND_W-2:0], ge};
        if (ge) begin
          rem <= rem - dsh;
        end
      end
      dsh <= dsh >> 1;
      step <= step - 1'b1;
    end
  end

endmodule

// ----- tb/band_column_checker.sv -----
// checker for the band column reducer: tracks each column, predicts its result and compares
module band_column_checker import bcr_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_COLUMN_ENTRIES_DEF,
  parameter logic [2:0] RULE_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: sample_low, sample_mid, sample_high, column_count, zero pad
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        s_tlast,
  // m_tdata: out_low, out_mid, out_high
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          columns_due,
  output int          column_errors
);

  localparam int SUM_LIMIT = 255 * MAX_ENTRIES;
  localparam int SUM_W = $clog2(SUM_LIMIT + 1);
  localparam int POS_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [RULE_W-1:0] rule;
  logic [SUM_W-1:0]  band_sum  [N_BANDS];
  logic [BAND_W-1:0] band_peak [N_BANDS];
  logic [BAND_W-1:0] band_pick [N_BANDS];
  logic [POS_W-1:0]  position;
  band_vec_t         column_results [$];

  task automatic report_error(input string msg);
    $display("error at %0t: %s", $time, msg);
    column_errors++;
  endtask

  task automatic clear_column();
    for (int b = 0; b < N_BANDS; b++) begin
      band_sum[b] = '0;
      band_peak[b] = '0;
      band_pick[b] = '0;
    end
    position = '0;
  endtask

  // fold one sample into the column; a closing sample yields the reduced result
  task automatic fold_sample(input logic [39:0] d, input logic closes);
    int span;
    int middle;
    int total;
    logic [BAND_W-1:0] smp;
    band_vec_t reduced;
    span = int'(d[36:24]);
    if (span == 0) begin
      span = 1;
    end else if (span > MAX_ENTRIES) begin
      span = MAX_ENTRIES;
    end
    middle = (span - 1) / 2;
    for (int b = 0; b < N_BANDS; b++) begin
      smp = d[BAND_W*b +: BAND_W];
      total = int'(band_sum[b]) + int'(smp);
      band_sum[b] = (total > SUM_LIMIT) ? SUM_W'(SUM_LIMIT) : SUM_W'(total);
      if (smp > band_peak[b]) begin
        band_peak[b] = smp;
      end
      if (int'(position) <= middle) begin
        band_pick[b] = smp;
      end
    end
    if (!closes) begin
      if (int'(position) < MAX_ENTRIES - 1) begin
        position = position + 1'b1;
      end
    end else begin
      for (int b = 0; b < N_BANDS; b++) begin
        case (rule)
          RULE_NEAREST: reduced[b] = band_pick[b];
          RULE_MEAN: begin
            total = int'(band_sum[b]) / span;
            reduced[b] = (total > 255) ? {BAND_W{1'b1}} : total[BAND_W-1:0];
          end
          // the spare code reduces like max
          default: reduced[b] = band_peak[b];
        endcase
      end
      column_results.push_back(reduced);
      clear_column();
    end
  endtask

  task automatic check_column(input logic [23:0] got);
    band_vec_t want;
    string band_name [N_BANDS];
    band_name = '{"out_low", "out_mid", "out_high"};
    if (column_results.size() == 0) begin
      report_error($sformatf("result %h with no column closed", got));
    end else begin
      want = column_results.pop_front();
      for (int b = 0; b < N_BANDS; b++) begin
        if (got[BAND_W*b +: BAND_W] !== want[b]) begin
          report_error($sformatf("%s got %0d expected %0d", band_name[b],
                                 got[BAND_W*b +: BAND_W], want[b]));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rule = RULE_RESET;
      clear_column();
      column_results.delete();
      columns_due <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_column(m_tdata);
      end
      if (s_tvalid && s_tready) begin
        fold_sample(s_tdata, s_tlast);
      end
      if (psel && penable && pwrite && pready && paddr == RULE_ADDR) begin
        rule = pwdata[RULE_W-1:0];
      end
      columns_due <= column_results.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// top of the band column reducer testbench: clock, reset, stimulus and verdict
module testbench import bcr_pkg::*; ();

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 100;
  localparam int LONG_COLUMN = 250;
  localparam logic [2:0] ADDR_RULE = 3'd0;
  localparam logic [RULE_W-1:0] RULE_SPARE = 2'd3;
  localparam logic [RULE_W-1:0] RULE_CYCLE [4] = '{RULE_NEAREST, RULE_MEAN, RULE_MAX,
                                                   RULE_SPARE};

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // s_tdata: sample_low, sample_mid, sample_high, column_count, zero pad
  logic [39:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // m_tdata: out_low, out_mid, out_high
  logic [23:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int columns_due;
  int column_errors;
  logic hold_wanted = 1'b0;
  logic long_hold_done = 1'b0;
  logic quiet_tail = 1'b0;

  band_column_reducer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  band_column_checker #(.RULE_ADDR(ADDR_RULE)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .columns_due   (columns_due),
    .column_errors (column_errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // result side: random ready stretches, one long hold-off, steady ready at the tail
  initial begin : result_sink
    int stretch;
    @(posedge clk);
    forever begin
      if (hold_wanted && !long_hold_done) begin
        m_tready <= 1'b0;
        for (stretch = 0; stretch < LONG_HOLD; stretch++) begin
          @(posedge clk);
        end
        long_hold_done = 1'b1;
      end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        stretch = quiet_tail ? 1 : $urandom_range(1, 20);
        repeat (stretch) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] band_level();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_sample(input logic [7:0] lo, input logic [7:0] mi,
                             input logic [7:0] hi, input logic [12:0] span,
                             input logic closes);
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, span, hi, mi, lo};
    s_tlast <= closes;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause_sender(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_column(input int len, input int span, input bit vary_span);
    for (int i = 0; i < len; i++) begin
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        pause_sender($urandom_range(1, 15));
      end
      send_sample(band_level(), band_level(), band_level(),
                  vary_span ? 13'($urandom_range(0, 8191)) : 13'(span), i == len - 1);
    end
  endtask

  // let every closed column drain, then wait out any sample still at work
  task automatic drain_block();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (columns_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rule(input logic [RULE_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_RULE;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : stimulus
    int phase;
    int sent;
    int len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // max rule out of reset, extreme levels, count of zero
    send_sample(8'd0, 8'd255, 8'd0, 13'd3, 1'b0);
    send_sample(8'd255, 8'd0, 8'd128, 13'd3, 1'b0);
    send_sample(8'd1, 8'd1, 8'd255, 13'd3, 1'b1);
    send_sample(8'd255, 8'd255, 8'd255, 13'd0, 1'b1);
    drain_block();

    // mean: full column, overlong column saturating, counts above the bound
    write_rule(RULE_MEAN);
    send_sample(8'd255, 8'd255, 8'd255, 13'd2, 1'b0);
    send_sample(8'd255, 8'd255, 8'd255, 13'd2, 1'b1);
    send_sample(8'd200, 8'd100, 8'd50, 13'd1, 1'b0);
    send_sample(8'd200, 8'd100, 8'd50, 13'd1, 1'b0);
    send_sample(8'd200, 8'd100, 8'd50, 13'd1, 1'b1);
    send_sample(8'd255, 8'd128, 8'd7, 13'd8191, 1'b0);
    send_sample(8'd255, 8'd128, 8'd7, 13'd8191, 1'b1);
    send_sample(8'd17, 8'd0, 8'd255, 13'd4097, 1'b1);
    drain_block();

    // nearest: exact column, early end, count changing inside the column
    write_rule(RULE_NEAREST);
    for (int i = 0; i < 5; i++) begin
      send_sample(8'(10 + i), 8'(100 + i), 8'(250 - i), 13'd5, i == 4);
    end
    send_sample(8'd40, 8'd41, 8'd42, 13'd6, 1'b0);
    send_sample(8'd43, 8'd44, 8'd45, 13'd6, 1'b1);
    send_sample(8'd30, 8'd60, 8'd90, 13'd9, 1'b0);
    send_sample(8'd31, 8'd61, 8'd91, 13'd1, 1'b0);
    send_sample(8'd32, 8'd62, 8'd92, 13'd1, 1'b1);
    drain_block();

    write_rule(RULE_SPARE);
    send_sample(8'd5, 8'd250, 8'd9, 13'd2, 1'b0);
    send_sample(8'd250, 8'd5, 8'd9, 13'd2, 1'b1);
    drain_block();

    // one long full-scale column, far shorter than its count
    write_rule(RULE_MEAN);
    for (sent = 0; sent < LONG_COLUMN; sent++) begin
      send_sample(8'hFF, 8'hFF, 8'hFF, 13'd4096, sent == LONG_COLUMN - 1);
    end
    drain_block();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet_tail = (phase >= RANDOM_PHASES - 2);
      write_rule(phase < 4 ? RULE_CYCLE[phase] : RULE_CYCLE[$urandom_range(0, 3)]);
      hold_wanted = (phase == 5);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          0, 1: begin
            len = $urandom_range(1, 12);
            send_column(len, $urandom_range(0, 8191), 1'b0);
          end
          2: begin
            len = $urandom_range(2, 10);
            send_column(len, 0, 1'b1);
          end
          3: begin
            len = $urandom_range(9, 40);
            send_column(len, len, 1'b0);
          end
          default: begin
            len = $urandom_range(1, 8);
            send_column(len, len, 1'b0);
          end
        endcase
        sent += len;
      end
      drain_block();
    end

    if (column_errors == 0 && columns_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- band_column_reducer_top.f -----
rtl/core/bcr_pkg.sv
rtl/core/bcr_accum.sv
rtl/core/bcr_div.sv
rtl/core/band_column_reducer_top.sv
tb/band_column_checker.sv
tb/testbench.sv
